[rtl/srpg_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// srpg_pkg
// Types, widths and small lookup functions for the stepper ramp pulse generator.
// ----------------------------------------------------------------------------
package srpg_pkg;

    localparam int STEP_W   = 16;              // step counter width
    localparam int HP_W     = 14;              // base half-period width
    localparam int H_W      = 15;              // effective half-period / tick counter
    localparam int SLOPE_W  = 7;
    localparam int MODE_W   = 2;
    localparam int DIV_DW   = STEP_W + 15;     // dividend: 2*S*num + Q
    localparam int DIV_VW   = STEP_W + 1;      // divisor: 2*Q
    localparam int DIV_CW   = $clog2(DIV_DW + 1);
    localparam int PROD_W   = STEP_W + HP_W;

    localparam logic [HP_W-1:0]    LIMIT_RESET = 14'd10000;
    localparam logic [SLOPE_W-1:0] SLOPE_MAX   = 7'd100;

    // microstep divisor codes and pin encodings (bit0 = M0, bit1 = M1)
    localparam logic [7:0]        USTEP_8   = 8'd8;
    localparam logic [7:0]        USTEP_16  = 8'd16;
    localparam logic [7:0]        USTEP_32  = 8'd32;
    localparam logic [MODE_W-1:0] MODE_8    = 2'b00;
    localparam logic [MODE_W-1:0] MODE_16   = 2'b11;
    localparam logic [MODE_W-1:0] MODE_32   = 2'b01;
    localparam logic [MODE_W-1:0] MODE_64   = 2'b10;

    localparam logic OP_TICK  = 1'b0;
    localparam logic OP_START = 1'b1;

    typedef struct packed {
        logic        op;
        logic [15:0] move_steps;
        logic [13:0] half_period_us;
        logic [6:0]  slope_percent;
        logic        direction;
        logic [7:0]  step_mode;
        logic        hold;
        logic        estop;
    } in_word_t;

    typedef struct packed {
        logic       step_level;
        logic       dir_level;
        logic       drive_enabled;
        logic [1:0] mode_bits;
        logic       busy_res;
        logic       aborted;
    } out_word_t;

    function automatic logic [MODE_W-1:0] mode_of(input logic [7:0] m);
        logic [MODE_W-1:0] r;
        case (m)
            USTEP_8:  r = MODE_8;
            USTEP_16: r = MODE_16;
            USTEP_32: r = MODE_32;
            default:  r = MODE_64;
        endcase
        return r;
    endfunction

    // floor(100 / slope) for slope 1..100 (slope already clamped)
    function automatic logic [SLOPE_W-1:0] ramp_div_of(input logic [SLOPE_W-1:0] s);
        logic [SLOPE_W-1:0] r;
        if (s <= 7'd1)       r = 7'd100;
        else if (s == 7'd2)  r = 7'd50;
        else if (s == 7'd3)  r = 7'd33;
        else if (s == 7'd4)  r = 7'd25;
        else if (s == 7'd5)  r = 7'd20;
        else if (s == 7'd6)  r = 7'd16;
        else if (s == 7'd7)  r = 7'd14;
        else if (s == 7'd8)  r = 7'd12;
        else if (s == 7'd9)  r = 7'd11;
        else if (s == 7'd10) r = 7'd10;
        else if (s == 7'd11) r = 7'd9;
        else if (s == 7'd12) r = 7'd8;
        else if (s <= 7'd14) r = 7'd7;
        else if (s <= 7'd16) r = 7'd6;
        else if (s <= 7'd20) r = 7'd5;
        else if (s <= 7'd25) r = 7'd4;
        else if (s <= 7'd33) r = 7'd3;
        else if (s <= 7'd50) r = 7'd2;
        else                 r = 7'd1;
        return r;
    endfunction

endpackage

[rtl/stepper_ramp_pulse_generator.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stepper_ramp_pulse_generator
// Step/dir pulse generator with a linear speed ramp, one shared divider.
// ----------------------------------------------------------------------------
// Usage:
//  - Input channel (s_valid/s_ready/s_data): each word is either a 1 us tick
//    (op = 0) or a start-move command (op = 1). estop is sampled on every word.
//  - Result channel (m_valid/m_ready/m_data): exactly one word per input word,
//    giving the pin levels (step, dir, enable, mode, busy, aborted) after it.
//  - cfg_wr_en/cfg_wr_data write the half-period clamp; write only while idle.
//  - One word at a time. A tick that ends a step inside a ramp recomputes the
//    half-period through the multiplier and the bit-serial divider. A start
//    with a ramp runs the divider for the ramp length, then, if that is not
//    zero, for the first half-period. The divider loop yields one quotient
//    bit per cycle, DIV_DW bits in all.
//  - s_ready is high only in the idle state. A finished result waits in the
//    output register; if the receiver stalls the next word may still be taken
//    and processed, and it holds in the done state until the slot frees up.
//  - Reset: idle, drive disabled, step pin low, limit = 10000, no result held.
// ----------------------------------------------------------------------------
module stepper_ramp_pulse_generator
    import srpg_pkg::*;
(
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             cfg_wr_en,
    input  logic [HP_W-1:0]  cfg_wr_data,
    input  logic             s_valid,
    output logic             s_ready,
    input  in_word_t         s_data,
    output logic             m_valid,
    input  logic             m_ready,
    output out_word_t        m_data
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_HALF,
        S_MUL,
        S_DLD,
        S_DIV,
        S_DONE
    } state_t;

    state_t              state_reg;
    in_word_t            in_reg;
    logic [HP_W-1:0]     limit_reg;

    // move state
    logic [STEP_W-1:0]   step_index_reg;
    logic [STEP_W-1:0]   total_steps_reg;
    logic [HP_W-1:0]     base_hp_reg;
    logic [STEP_W-1:0]   ramp_len_reg;
    logic [H_W-1:0]      cur_hp_reg;
    logic [H_W-1:0]      tick_reg;
    logic                phase_high_reg;
    logic                busy_reg;
    logic                en_reg;
    logic                dir_reg;
    logic                hold_reg;
    logic                abort_reg;
    logic [MODE_W-1:0]   mode_reg;

    // ramp arithmetic
    logic [STEP_W-1:0]   num_reg;
    logic [PROD_W-1:0]   prod_reg;
    logic [DIV_DW-1:0]   dq_reg;        // dividend shifting out, quotient shifting in
    logic [DIV_VW-1:0]   rem_reg;
    logic [DIV_VW-1:0]   dvs_reg;
    logic [DIV_CW-1:0]   cnt_reg;
    logic                div_ramp_reg;  // 1: ramp length divide, 0: half-period divide

    logic                m_valid_reg;
    out_word_t           out_reg;

    // combinational helpers
    logic [HP_W-1:0]     s_clamp;
    logic [SLOPE_W-1:0]  slope_c;
    logic [STEP_W-1:0]   steps_in;
    logic [MODE_W-1:0]   mode_in;
    logic [H_W-1:0]      tick_inc;
    logic [STEP_W-1:0]   idx_inc;
    logic [STEP_W+1:0]   i2, q2, n2, left2, num_w;
    logic [DIV_VW:0]     rem_sh, trial;
    logic                div_ge;
    logic [DIV_DW-1:0]   quot;
    logic [H_W:0]        h_sum;
    logic [H_W-1:0]      base_min1;
    logic                out_free;

    always_comb begin
        s_clamp   = (in_reg.half_period_us > limit_reg) ? limit_reg : in_reg.half_period_us;
        slope_c   = (in_reg.slope_percent > SLOPE_MAX) ? SLOPE_MAX : in_reg.slope_percent;
        steps_in  = STEP_W'(in_reg.move_steps);
        mode_in   = mode_of(in_reg.step_mode);
        tick_inc  = tick_reg + H_W'(1);
        idx_inc   = step_index_reg + STEP_W'(1);

        // distance into the ramp: accel at the start, decel at the end
        i2    = {1'b0, step_index_reg, 1'b0};
        q2    = {2'b00, ramp_len_reg};
        n2    = {1'b0, total_steps_reg, 1'b0};
        left2 = {1'b0, total_steps_reg - step_index_reg, 1'b0};
        num_w = '0;
        if (q2 > i2) begin
            num_w = q2 - i2;
        end
        if (i2 + q2 > n2) begin
            num_w = q2 - left2;
        end

        // restoring divider step
        rem_sh = {rem_reg, dq_reg[DIV_DW-1]};
        trial  = rem_sh - {1'b0, dvs_reg};
        div_ge = ~trial[DIV_VW];
        quot   = {dq_reg[DIV_DW-2:0], div_ge};

        h_sum     = {1'b0, H_W'(base_hp_reg)} + {1'b0, quot[H_W-1:0]};
        base_min1 = (base_hp_reg == '0) ? H_W'(1) : H_W'(base_hp_reg);

        out_free  = ~m_valid_reg | m_ready;
    end

    assign s_ready = (state_reg == S_IDLE);
    assign m_valid = m_valid_reg;
    assign m_data  = out_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= S_IDLE;
            limit_reg       <= LIMIT_RESET;
            step_index_reg  <= '0;
            total_steps_reg <= '0;
            base_hp_reg     <= '0;
            ramp_len_reg    <= '0;
            cur_hp_reg      <= '0;
            tick_reg        <= '0;
            phase_high_reg  <= 1'b0;
            busy_reg        <= 1'b0;
            en_reg          <= 1'b0;
            dir_reg         <= 1'b0;
            hold_reg        <= 1'b0;
            abort_reg       <= 1'b0;
            mode_reg        <= '0;
            div_ramp_reg    <= 1'b0;
            m_valid_reg     <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                limit_reg <= cfg_wr_data;
            end
            // the done state reloads the slot itself
            if (m_valid_reg && m_ready && state_reg != S_DONE) begin
                m_valid_reg <= 1'b0;
            end

            case (state_reg)
                S_IDLE: begin
                    if (s_valid) begin
                        in_reg    <= s_data;
                        state_reg <= S_EXEC;
                    end
                end

                S_EXEC: begin
                    if (in_reg.estop) begin
                        busy_reg <= 1'b0;
                        en_reg   <= 1'b0;
                        if (busy_reg || in_reg.op == OP_START) begin
                            abort_reg <= 1'b1;
                        end
                        if (in_reg.op == OP_START) begin
                            // latch pins, start nothing
                            dir_reg  <= in_reg.direction;
                            hold_reg <= in_reg.hold;
                            mode_reg <= mode_in;
                        end
                        state_reg <= S_DONE;
                    end else if (in_reg.op == OP_START) begin
                        if (!busy_reg) begin
                            dir_reg         <= in_reg.direction;
                            hold_reg        <= in_reg.hold;
                            mode_reg        <= mode_in;
                            abort_reg       <= 1'b0;
                            total_steps_reg <= steps_in;
                            base_hp_reg     <= s_clamp;
                            step_index_reg  <= '0;
                            tick_reg        <= '0;
                            if (steps_in == '0) begin
                                ramp_len_reg <= '0;
                                en_reg       <= in_reg.hold;
                                busy_reg     <= 1'b0;
                                state_reg    <= S_DONE;
                            end else begin
                                en_reg         <= 1'b1;
                                busy_reg       <= 1'b1;
                                phase_high_reg <= 1'b0;
                                if (slope_c == '0) begin
                                    ramp_len_reg <= '0;
                                    state_reg    <= S_HALF;
                                end else begin
                                    dq_reg       <= DIV_DW'(steps_in);
                                    rem_reg      <= '0;
                                    dvs_reg      <= DIV_VW'(ramp_div_of(slope_c));
                                    cnt_reg      <= DIV_CW'(DIV_DW - 1);
                                    div_ramp_reg <= 1'b1;
                                    state_reg    <= S_DIV;
                                end
                            end
                        end else begin
                            state_reg <= S_DONE;
                        end
                    end else if (busy_reg) begin
                        // tick
                        if (tick_inc < cur_hp_reg) begin
                            tick_reg  <= tick_inc;
                            state_reg <= S_DONE;
                        end else begin
                            tick_reg <= '0;
                            if (!phase_high_reg) begin
                                phase_high_reg <= 1'b1;
                                state_reg      <= S_DONE;
                            end else begin
                                step_index_reg <= idx_inc;
                                if (idx_inc >= total_steps_reg) begin
                                    busy_reg <= 1'b0;
                                    if (!hold_reg) begin
                                        en_reg <= 1'b0;
                                    end
                                    state_reg <= S_DONE;
                                end else begin
                                    phase_high_reg <= 1'b0;
                                    state_reg      <= S_HALF;
                                end
                            end
                        end
                    end else begin
                        state_reg <= S_DONE;
                    end
                end

                S_HALF: begin
                    if (num_w == '0) begin
                        cur_hp_reg <= base_min1;
                        state_reg  <= S_DONE;
                    end else begin
                        num_reg   <= num_w[STEP_W-1:0];
                        state_reg <= S_MUL;
                    end
                end

                S_MUL: begin
                    prod_reg  <= PROD_W'(base_hp_reg) * PROD_W'(num_reg);
                    state_reg <= S_DLD;
                end

                S_DLD: begin
                    // round(S*num/Q) = floor((2*S*num + Q) / (2*Q))
                    dq_reg       <= {prod_reg, 1'b0} + DIV_DW'(ramp_len_reg);
                    rem_reg      <= '0;
                    dvs_reg      <= {ramp_len_reg, 1'b0};
                    cnt_reg      <= DIV_CW'(DIV_DW - 1);
                    div_ramp_reg <= 1'b0;
                    state_reg    <= S_DIV;
                end

                S_DIV: begin
                    dq_reg  <= quot;
                    rem_reg <= div_ge ? trial[DIV_VW-1:0] : rem_sh[DIV_VW-1:0];
                    cnt_reg <= cnt_reg - DIV_CW'(1);
                    if (cnt_reg == '0) begin
                        if (div_ramp_reg) begin
                            ramp_len_reg <= quot[STEP_W-1:0];
                            state_reg    <= S_HALF;
                        end else begin
                            cur_hp_reg <= (h_sum[H_W-1:0] == '0) ? H_W'(1) : h_sum[H_W-1:0];
                            state_reg  <= S_DONE;
                        end
                    end
                end

                S_DONE: begin
                    if (out_free) begin
                        out_reg.step_level    <= phase_high_reg;
                        out_reg.dir_level     <= dir_reg;
                        out_reg.drive_enabled <= en_reg;
                        out_reg.mode_bits     <= mode_reg;
                        out_reg.busy_res      <= busy_reg;
                        out_reg.aborted       <= abort_reg;
                        m_valid_reg           <= 1'b1;
                        state_reg             <= S_IDLE;
                    end
                end

                default: begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

endmodule
